// File: rtl/core/baro_sensor_compensation_core_defines.svh
// Assertion macros for the barometric compensation core checker.
// Included by the checker file only.
`ifndef BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// clocked assertion, off while reset is high
`define BSC_ASSERT(lbl, expr, msg) lbl: assert property (@(posedge clk) disable iff (rst) \
  (expr)) else $error(msg);

// clocked assertion that also holds across reset
`define BSC_ASSERT_ALWAYS(lbl, expr, msg) lbl: assert property (@(posedge clk) \
  (expr)) else $error(msg);

`endif

// File: rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation core.
// No dependencies.
`default_nettype none
package bsc_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OSS   = 3'd3;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] K_3038     = 32'd3038;
  localparam logic [31:0] K_7357     = 32'd7357;
  localparam logic [31:0] K_3791     = 32'd3791;
  localparam logic [15:0] K_50000    = 16'd50000;
  localparam logic [31:0] K_32768    = 32'd32768;

  // one stage of a restoring divider
  typedef struct packed {
    logic [31:0] n;
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] d;
  } div_t;

  typedef struct packed {
    logic [18:0] up;
    logic [31:0] x1;
    logic        neg;
    logic        err;
  } tside_t;

  typedef struct packed {
    logic [15:0] temp;
    logic        pre_shift;
    logic        err;
  } pside_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/baro_sensor_compensation_core.sv
// Top level of the barometric compensation core: calibration registers and pipeline.
// Depends on bsc_pkg.
//
// Takes one raw temperature/pressure word per cycle and returns one compensated word
// per cycle while the output is not stalled. The two divisions (temperature
// correction and pressure) are restoring dividers unrolled into 32 registered
// stages each, one quotient bit per stage. A stall on the output holds every
// stage. Configuration writes are taken in any cycle and are meant to happen
// while the pipeline is empty.
`default_nettype none
module baro_sensor_compensation_core
  import bsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // raw_temp[15:0], raw_press[34:16]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // temp_tenths[15:0], press_pa[47:16],
                                                 // div_error[48]
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
      oss   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAL_A: cal_a <= cfg_data;
        CFG_CAL_B: cal_b <= cfg_data;
        CFG_CAL_C: cal_c <= cfg_data[31:0];
        CFG_OSS:   oss   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal_a[15]}}, cal_a[15:0]};
  assign ac2 = {{16{cal_a[31]}}, cal_a[31:16]};
  assign ac3 = {{16{cal_a[47]}}, cal_a[47:32]};
  assign ac4 = {16'b0, cal_a[63:48]};
  assign ac5 = {16'b0, cal_b[15:0]};
  assign ac6 = {16'b0, cal_b[31:16]};
  assign b1  = {{16{cal_b[47]}}, cal_b[47:32]};
  assign b2  = {{16{cal_b[63]}}, cal_b[63:48]};
  assign mc  = {{16{cal_c[15]}}, cal_c[15:0]};
  assign md  = {{16{cal_c[31]}}, cal_c[31:16]};

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // s0: temperature product
  logic        v0;
  logic [18:0] up0;
  logic [31:0] prod0;
  logic [31:0] t_diff;
  assign t_diff = {16'b0, s_tdata[15:0]} - ac6;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      up0   <= s_tdata[34:16];
      prod0 <= t_diff * ac5;
    end
  end

  // s1: set up the signed temperature division as magnitudes
  logic        d1v [0:32];
  div_t        d1  [0:32];
  tside_t      d1s [0:32];
  logic [31:0] x1_t, den_t, num_t;
  assign x1_t  = asr32(prod0, 11'd15);
  assign den_t = x1_t + md;
  assign num_t = mc << 11;

  always_ff @(posedge clk) begin
    if (rst) d1v[0] <= 1'b0;
    else if (en) d1v[0] <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0].n     <= num_t[31] ? 32'(-num_t) : num_t;
      d1[0].d     <= den_t[31] ? 32'(-den_t) : den_t;
      d1[0].q     <= '0;
      d1[0].r     <= '0;
      d1s[0].up   <= up0;
      d1s[0].x1   <= x1_t;
      d1s[0].neg  <= num_t[31] ^ den_t[31];
      d1s[0].err  <= (den_t == '0);
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_div1
    logic [32:0] rs;
    logic        ge;
    assign rs = {d1[k].r, d1[k].n[31-k]};
    assign ge = rs >= {1'b0, d1[k].d};
    always_ff @(posedge clk) begin
      if (rst) d1v[k+1] <= 1'b0;
      else if (en) d1v[k+1] <= d1v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1[k+1].n <= d1[k].n;
        d1[k+1].d <= d1[k].d;
        d1[k+1].q <= {d1[k].q[30:0], ge};
        d1[k+1].r <= ge ? 32'(rs - {1'b0, d1[k].d}) : rs[31:0];
        d1s[k+1]  <= d1s[k];
      end
    end
  end

  // T: temperature result and b6
  logic        tv, t_err;
  logic [15:0] t_temp;
  logic [31:0] t_b6;
  logic [18:0] t_up;
  logic [31:0] x2_t, b5_t;
  assign x2_t = d1s[32].neg ? 32'(-d1[32].q) : d1[32].q;
  assign b5_t = d1s[32].x1 + x2_t;

  always_ff @(posedge clk) begin
    if (rst) tv <= 1'b0;
    else if (en) tv <= d1v[32];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t_temp <= 16'(asr32(b5_t + 32'd8, 3'd4));
      t_b6   <= b5_t - B6_OFFSET;
      t_up   <= d1s[32].up;
      t_err  <= d1s[32].err;
    end
  end

  // P1: products of b6
  logic        p1v, p1_err;
  logic [15:0] p1_temp;
  logic [18:0] p1_up;
  logic [31:0] p1_sq, p1_ac2, p1_ac3;
  always_ff @(posedge clk) begin
    if (rst) p1v <= 1'b0;
    else if (en) p1v <= tv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1_sq   <= t_b6 * t_b6;
      p1_ac2  <= ac2 * t_b6;
      p1_ac3  <= ac3 * t_b6;
      p1_temp <= t_temp;
      p1_up   <= t_up;
      p1_err  <= t_err;
    end
  end

  // P2: products of sq
  logic        p2v, p2_err;
  logic [15:0] p2_temp;
  logic [18:0] p2_up;
  logic [31:0] p2_b2, p2_b1, p2_ac2, p2_ac3, sq_t;
  assign sq_t = asr32(p1_sq, 12);
  always_ff @(posedge clk) begin
    if (rst) p2v <= 1'b0;
    else if (en) p2v <= p1v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p2_b2   <= b2 * sq_t;
      p2_b1   <= b1 * sq_t;
      p2_ac2  <= p1_ac2;
      p2_ac3  <= p1_ac3;
      p2_temp <= p1_temp;
      p2_up   <= p1_up;
      p2_err  <= p1_err;
    end
  end

  // P3: b3 and the b4 factor
  logic        p3v, p3_err;
  logic [15:0] p3_temp;
  logic [18:0] p3_up;
  logic [31:0] p3_b3, p3_term;
  logic [31:0] x3_a, x3_b;
  assign x3_a = asr32(p2_b2, 11) + asr32(p2_ac2, 11);
  assign x3_b = asr32(asr32(p2_ac3, 13) + asr32(p2_b1, 16) + 32'd2, 2);
  always_ff @(posedge clk) begin
    if (rst) p3v <= 1'b0;
    else if (en) p3v <= p2v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p3_b3   <= asr32((((ac1 << 2) + x3_a) << oss) + 32'd2, 2);
      p3_term <= x3_b + K_32768;
      p3_temp <= p2_temp;
      p3_up   <= p2_up;
      p3_err  <= p2_err;
    end
  end

  // P4: b4 product and pressure offset
  logic        p4v, p4_err;
  logic [15:0] p4_temp;
  logic [31:0] p4_b4m, p4_diff;
  always_ff @(posedge clk) begin
    if (rst) p4v <= 1'b0;
    else if (en) p4v <= p3v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p4_b4m  <= ac4 * p3_term;
      p4_diff <= {13'b0, p3_up} - p3_b3;
      p4_temp <= p3_temp;
      p4_err  <= p3_err;
    end
  end

  // P5: b4 and b7
  logic        p5v, p5_err;
  logic [15:0] p5_temp;
  logic [31:0] p5_b4, p5_b7, b4_t;
  logic [15:0] scale_t;
  assign b4_t    = p4_b4m >> 15;
  assign scale_t = K_50000 >> oss;
  always_ff @(posedge clk) begin
    if (rst) p5v <= 1'b0;
    else if (en) p5v <= p4v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p5_b4   <= b4_t;
      p5_b7   <= p4_diff * {16'b0, scale_t};
      p5_temp <= p4_temp;
      p5_err  <= p4_err || (b4_t == '0);
    end
  end

  // P6: set up the unsigned pressure division
  logic        d2v [0:32];
  div_t        d2  [0:32];
  pside_t      d2s [0:32];
  always_ff @(posedge clk) begin
    if (rst) d2v[0] <= 1'b0;
    else if (en) d2v[0] <= p5v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d2[0].n           <= p5_b7[31] ? p5_b7 : {p5_b7[30:0], 1'b0};
      d2[0].d           <= p5_b4;
      d2[0].q           <= '0;
      d2[0].r           <= '0;
      d2s[0].temp       <= p5_temp;
      d2s[0].pre_shift  <= !p5_b7[31];
      d2s[0].err        <= p5_err;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_div2
    logic [32:0] rs;
    logic        ge;
    assign rs = {d2[k].r, d2[k].n[31-k]};
    assign ge = rs >= {1'b0, d2[k].d};
    always_ff @(posedge clk) begin
      if (rst) d2v[k+1] <= 1'b0;
      else if (en) d2v[k+1] <= d2v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2[k+1].n <= d2[k].n;
        d2[k+1].d <= d2[k].d;
        d2[k+1].q <= {d2[k].q[30:0], ge};
        d2[k+1].r <= ge ? 32'(rs - {1'b0, d2[k].d}) : rs[31:0];
        d2s[k+1]  <= d2s[k];
      end
    end
  end

  // Q1: p and its products
  logic        q1v, q1_err;
  logic [15:0] q1_temp;
  logic [31:0] q1_p, q1_sqp, q1_m7, p_t, pa_t;
  assign p_t  = d2s[32].pre_shift ? d2[32].q : {d2[32].q[30:0], 1'b0};
  assign pa_t = asr32(p_t, 8);
  always_ff @(posedge clk) begin
    if (rst) q1v <= 1'b0;
    else if (en) q1v <= d2v[32];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q1_p    <= p_t;
      q1_sqp  <= pa_t * pa_t;
      q1_m7   <= K_7357 * p_t;
      q1_temp <= d2s[32].temp;
      q1_err  <= d2s[32].err;
    end
  end

  // Q2: scale the square term
  logic        q2v, q2_err;
  logic [15:0] q2_temp;
  logic [31:0] q2_p, q2_m3, q2_m7;
  always_ff @(posedge clk) begin
    if (rst) q2v <= 1'b0;
    else if (en) q2v <= q1v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q2_m3   <= q1_sqp * K_3038;
      q2_p    <= q1_p;
      q2_m7   <= q1_m7;
      q2_temp <= q1_temp;
      q2_err  <= q1_err;
    end
  end

  // output register; zero the results and set div_error on a divide error
  logic [31:0] pf_t;
  assign pf_t = q2_p + asr32(asr32(q2_m3, 16) + asr32(32'(-q2_m7), 16) + K_3791, 4);
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= q2v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[15:0]  <= q2_err ? 16'b0 : q2_temp;
      m_tdata[47:16] <= q2_err ? 32'b0 : pf_t;
      m_tdata[48]    <= q2_err;
      m_tdata[55:49] <= '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bsc_checker.sv
// Port-level checker for the barometric compensation core, bound to the top level.
// Depends on bsc_pkg and baro_sensor_compensation_core_defines.svh.
`default_nettype none
`include "baro_sensor_compensation_core_defines.svh"
module bsc_checker
  import bsc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  `BSC_ASSERT(a_hold_out, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word dropped or changed under stall")
  `BSC_ASSERT(a_ready_flow, s_tready == (!m_tvalid || m_tready), "input ready does not follow output flow")
  `BSC_ASSERT(a_err_zero, m_tvalid && m_tdata[48] |-> m_tdata[47:0] == 48'b0, "divide error word carries nonzero results")
  `BSC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
